>>> rtl/core/glu_pkg.sv
// Shared constants and operation codes for the gcd/lcm unit.
package glu_pkg;

	localparam int DATA_WIDTH_DEF = 64;
	localparam int OPER_W         = 64;
	localparam int RES_W          = 63;

	localparam logic KIND_GCD = 1'b0;
	localparam logic KIND_LCM = 1'b1;

endpackage

>>> rtl/core/glu_addsub.sv
// Shared add/subtract unit used by the negate, gcd, divide and multiply steps of the gcd/lcm sequencer.
module glu_addsub #(
	parameter int DATA_WIDTH = glu_pkg::DATA_WIDTH_DEF
) (
	input  logic [DATA_WIDTH:0] a,
	input  logic [DATA_WIDTH:0] b,
	input  logic                sub,
	output logic [DATA_WIDTH:0] sum,
	output logic                carry
);

	logic [DATA_WIDTH:0] b_eff;

	assign b_eff = b ^ {(DATA_WIDTH + 1){sub}};

	// carry out on subtract means a >= b
	assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + (DATA_WIDTH + 2)'(sub);

endmodule

>>> rtl/core/gcd_lcm_unit.sv
// Top level: sequencer and registers of the iterative gcd/lcm unit.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------
//  in      | in_valid  | in_stall  | kind, operand_a, operand_b
//  out     | out_valid | out_stall | result, status
//
// One transaction at a time through a single add/subtract unit.
// After acceptance: magnitudes of both operands, then the binary gcd loop
// (halving, swap, subtract), shift-back steps, a result step and the output
// load; lcm adds divide steps and shift-add multiply steps, and an lcm with a
// zero operand goes straight to the output load. Idle before the next one.
// in_stall is high from acceptance until the result moves to the output
// register, which holds it while out_stall is high. arst_n clears control.
module gcd_lcm_unit #(
	parameter int DATA_WIDTH = glu_pkg::DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic [glu_pkg::OPER_W-1:0] operand_a,
	input  logic [glu_pkg::OPER_W-1:0] operand_b,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [glu_pkg::RES_W-1:0]  result,
	output logic                      status
);

	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(W + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_NEG_A, ST_NEG_B, ST_GCD, ST_SHIFT, ST_DIV, ST_MUL, ST_FINISH
	} state_t;

	state_t                  state_q;
	logic                    kind_q;
	logic [W-1:0]            ma_q, mb_q, x_q, y_q, rem_q, quo_q, acc_q, res_q;
	logic [CW-1:0]           cnt_q;
	logic                    ovf_q;
	logic                    out_valid_q, status_q;
	logic [glu_pkg::RES_W-1:0] result_q;

	logic [W:0]   alu_a, alu_b, alu_sum;
	logic         alu_sub, alu_carry;
	logic [W-1:0] mb_mag;
	logic         out_free;

	glu_addsub #(.DATA_WIDTH(W)) u_addsub (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_NEG_A: begin
				alu_b   = {1'b0, ma_q};
				alu_sub = 1'b1;
			end
			ST_NEG_B: begin
				alu_b   = {1'b0, mb_q};
				alu_sub = 1'b1;
			end
			ST_GCD: begin
				alu_a   = {1'b0, x_q};
				alu_b   = {1'b0, y_q};
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				alu_a   = {rem_q, quo_q[W-1]};
				alu_b   = {1'b0, x_q};
				alu_sub = 1'b1;
			end
			ST_MUL: begin
				alu_a = {acc_q, 1'b0};
				alu_b = quo_q[W-1] ? {1'b0, mb_q} : '0;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	assign mb_mag   = mb_q[W-1] ? alu_sum[W-1:0] : mb_q;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FINISH)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						ma_q    <= operand_a[W-1:0];
						mb_q    <= operand_b[W-1:0];
						state_q <= ST_NEG_A;
					end
				end
				ST_NEG_A: begin
					if (ma_q[W-1])
						ma_q <= alu_sum[W-1:0];
					state_q <= ST_NEG_B;
				end
				ST_NEG_B: begin
					mb_q  <= mb_mag;
					x_q   <= ma_q;
					y_q   <= mb_mag;
					cnt_q <= '0;
					ovf_q <= 1'b0;
					if (kind_q == glu_pkg::KIND_LCM && (ma_q == '0 || mb_mag == '0)) begin
						res_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (x_q == '0) begin
						x_q     <= y_q;
						state_q <= ST_SHIFT;
					end else if (y_q == '0) begin
						state_q <= ST_SHIFT;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q   <= x_q >> 1;
						y_q   <= y_q >> 1;
						cnt_q <= cnt_q + CW'(1);
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (alu_carry) begin
						x_q <= alu_sum[W-1:0];
					end else begin
						// keep x >= y for the next subtract
						x_q <= y_q;
						y_q <= x_q;
					end
				end
				ST_SHIFT: begin
					if (cnt_q != '0) begin
						x_q   <= x_q << 1;
						cnt_q <= cnt_q - CW'(1);
					end else if (kind_q == glu_pkg::KIND_GCD) begin
						// magnitude 2^(W-1) does not fit the signed range
						ovf_q   <= x_q[W-1];
						res_q   <= x_q[W-1] ? '0 : x_q;
						state_q <= ST_FINISH;
					end else begin
						rem_q   <= '0;
						quo_q   <= ma_q;
						cnt_q   <= CW'(W);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (alu_carry) begin
						rem_q <= alu_sum[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= alu_a[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
					if (cnt_q == CW'(1)) begin
						acc_q   <= '0;
						cnt_q   <= CW'(W);
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_MUL: begin
					// accumulator only grows, so overflow is sticky
					acc_q <= alu_sum[W-1:0];
					quo_q <= quo_q << 1;
					if (cnt_q == CW'(1)) begin
						ovf_q   <= ovf_q | alu_sum[W] | alu_sum[W-1];
						res_q   <= (ovf_q | alu_sum[W] | alu_sum[W-1]) ? '0 : alu_sum[W-1:0];
						state_q <= ST_FINISH;
					end else begin
						ovf_q <= ovf_q | alu_sum[W] | alu_sum[W-1];
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						result_q    <= glu_pkg::RES_W'(res_q[W-2:0]);
						status_q    <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign status    = status_q;

`ifndef SYNTH
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> result == '0)
		else $error("overflow result not zero");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("unit ready right after accepting a transaction");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_MUL) |-> cnt_q != '0 && cnt_q <= CW'(W))
		else $error("divide/multiply step counter out of range");
`endif

endmodule
